FILE: sv/esu_pkg.sv
package esu_pkg;

    localparam int MAX_RES   = 5;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_END  = 2'd1,
        ST_BAD  = 2'd2,
        ST_CODE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [RES_CNT_W-1:0]  cnt;
        t_res [MAX_RES-1:0]    ent;
    } t_batch;

endpackage

FILE: sv/esu_channels.sv
interface esu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_end;

    modport source (output valid, output in_byte, output is_end, input ready);
    modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface esu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

FILE: sv/esu_decode.sv
module esu_decode import esu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_batch     o_batch
);

    typedef enum logic [2:0] {
        M_NORMAL  = 3'd0,
        M_ESCAPE  = 3'd1,
        M_PLUS    = 3'd2,
        M_DIGITS  = 3'd3,
        M_DISCARD = 3'd4
    } t_mode;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [3:0] DIGITS_NARROW = 4'd4;
    localparam logic [3:0] DIGITS_WIDE   = 4'd8;

    typedef struct packed {
        logic                 ok;
        logic [2:0]           cnt;
        logic [3:0][7:0]      bytes;
    } t_utf8;

    t_mode       r_mode, n_mode;
    logic        r_wide, n_wide;
    logic [3:0]  r_dcnt, n_dcnt;
    logic [31:0] r_cp,   n_cp;

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] v;
        unique case (b)
            8'h61:   v = 8'd7;
            8'h62:   v = 8'd8;
            8'h66:   v = 8'd12;
            8'h6E:   v = 8'd10;
            8'h72:   v = 8'd13;
            8'h74:   v = 8'd9;
            8'h76:   v = 8'd11;
            default: v = b;
        endcase
        return v;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [31:0] c);
        t_utf8 e;
        e = '0;
        e.ok = !(c > 32'h0010_FFFF || (c >= 32'h0000_D800 && c <= 32'h0000_DFFF));
        if (c < 32'h80) begin
            e.cnt      = 3'd1;
            e.bytes[0] = c[7:0];
        end else if (c < 32'h800) begin
            e.cnt      = 3'd2;
            e.bytes[0] = {3'b110, c[10:6]};
            e.bytes[1] = {2'b10, c[5:0]};
        end else if (c < 32'h1_0000) begin
            e.cnt      = 3'd3;
            e.bytes[0] = {4'b1110, c[15:12]};
            e.bytes[1] = {2'b10, c[11:6]};
            e.bytes[2] = {2'b10, c[5:0]};
        end else begin
            e.cnt      = 3'd4;
            e.bytes[0] = {5'b11110, c[20:18]};
            e.bytes[1] = {2'b10, c[17:12]};
            e.bytes[2] = {2'b10, c[11:6]};
            e.bytes[3] = {2'b10, c[5:0]};
        end
        return e;
    endfunction

    logic            w_end;
    logic [4:0]      w_hex;
    logic [31:0]     w_cp_shift;
    logic [3:0]      w_dcnt_inc;
    t_utf8           w_enc;

    assign w_end      = i_end || (i_byte == 8'h00);
    assign w_hex      = w_end ? 5'd0 : hex_value(i_byte);
    assign w_cp_shift = {r_cp[27:0], w_hex[3:0]};
    assign w_dcnt_inc = r_dcnt + 4'd1;
    assign w_enc      = utf8_encode(w_hex[4] ? w_cp_shift : r_cp);

    always_comb begin
        logic tail;
        n_mode  = r_mode;
        n_wide  = r_wide;
        n_dcnt  = r_dcnt;
        n_cp    = r_cp;
        o_batch = '0;
        tail    = 1'b0;

        unique case (r_mode)
            M_ESCAPE: begin
                if (w_end) begin
                    o_batch.ent[0] = '{data: 8'd0, status: ST_BAD, last: 1'b1};
                    o_batch.cnt    = RES_CNT_W'(1);
                    n_mode         = M_NORMAL;
                end else if (i_byte == CH_LO_U || i_byte == CH_UP_U) begin
                    n_wide = (i_byte == CH_UP_U);
                    n_mode = M_PLUS;
                end else begin
                    o_batch.ent[0] = '{data: esc_map(i_byte), status: ST_DATA, last: 1'b0};
                    o_batch.cnt    = RES_CNT_W'(1);
                    n_mode         = M_NORMAL;
                end
            end
            M_PLUS: begin
                if (!w_end && i_byte == CH_PLUS) begin
                    n_dcnt = 4'd0;
                    n_cp   = 32'd0;
                    n_mode = M_DIGITS;
                end else begin
                    o_batch.ent[0] = '{data: 8'd0, status: ST_BAD, last: 1'b1};
                    o_batch.cnt    = RES_CNT_W'(1);
                    n_mode         = w_end ? M_NORMAL : M_DISCARD;
                end
            end
            M_DIGITS: begin
                if (w_hex[4]) begin
                    n_cp   = w_cp_shift;
                    n_dcnt = w_dcnt_inc;
                    if (w_dcnt_inc >= (r_wide ? DIGITS_WIDE : DIGITS_NARROW)) begin
                        if (w_enc.ok) begin
                            for (int k = 0; k < 4; k++) begin
                                o_batch.ent[k] = '{data: w_enc.bytes[k], status: ST_DATA,
                                                   last: 1'b0};
                            end
                            o_batch.cnt = RES_CNT_W'(w_enc.cnt);
                            n_mode      = M_NORMAL;
                        end else begin
                            o_batch.ent[0] = '{data: 8'd0, status: ST_CODE, last: 1'b1};
                            o_batch.cnt    = RES_CNT_W'(1);
                            n_mode         = M_DISCARD;
                        end
                    end
                end else if (!w_enc.ok) begin
                    o_batch.ent[0] = '{data: 8'd0, status: ST_CODE, last: 1'b1};
                    o_batch.cnt    = RES_CNT_W'(1);
                    n_mode         = w_end ? M_NORMAL : M_DISCARD;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        o_batch.ent[k] = '{data: w_enc.bytes[k], status: ST_DATA, last: 1'b0};
                    end
                    o_batch.cnt = RES_CNT_W'(w_enc.cnt);
                    n_mode      = M_NORMAL;
                    tail        = 1'b1;
                end
            end
            M_DISCARD: begin
                if (w_end) begin
                    n_mode = M_NORMAL;
                end
            end
            default: begin
                n_mode = M_NORMAL;
                tail   = 1'b1;
            end
        endcase

        if (tail) begin
            if (w_end) begin
                o_batch.ent[o_batch.cnt] = '{data: 8'd0, status: ST_END, last: 1'b1};
                o_batch.cnt              = o_batch.cnt + RES_CNT_W'(1);
            end else if (i_byte == CH_BSLASH) begin
                n_mode = M_ESCAPE;
            end else begin
                o_batch.ent[o_batch.cnt] = '{data: i_byte, status: ST_DATA, last: 1'b0};
                o_batch.cnt              = o_batch.cnt + RES_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_wide <= 1'b0;
            r_dcnt <= 4'd0;
            r_cp   <= 32'd0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_wide <= n_wide;
            r_dcnt <= n_dcnt;
            r_cp   <= n_cp;
        end
    end

endmodule

FILE: sv/escape_sequence_unquoter_core.sv
// The first result of a word is presented in the cycle after the word is accepted.
// One word per cycle while each word yields at most one result and o_out is ready; a word
// that yields several results holds the input while the result buffer drains.
// Reset: synchronous, active low; returns the parser to plain text and empties the
// result buffer.
module escape_sequence_unquoter_core import esu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    esu_in_if.sink       i_in,
    esu_out_if.source    o_out
);

    t_batch                w_batch;
    logic                  w_accept;
    logic                  w_pop;
    t_res [MAX_RES-1:0]    r_buf, n_buf;
    logic [RES_CNT_W-1:0]  r_rem, n_rem;

    assign w_pop      = o_out.valid && o_out.ready;
    assign i_in.ready = (r_rem == '0) || (r_rem == RES_CNT_W'(1) && o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    esu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_accept),
        .i_byte  (i_in.in_byte),
        .i_end   (i_in.is_end),
        .o_batch (w_batch)
    );

    always_comb begin
        n_buf = r_buf;
        n_rem = r_rem;
        if (w_accept) begin
            n_buf = w_batch.ent;
            n_rem = w_batch.cnt;
        end else if (w_pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                n_buf[k] = r_buf[k + 1];
            end
            n_buf[MAX_RES-1] = '0;
            n_rem            = r_rem - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_out.valid    = (r_rem != '0);
    assign o_out.out_byte = r_buf[0].data;
    assign o_out.status   = r_buf[0].status;
    assign o_out.last     = r_buf[0].last;

endmodule

FILE: tb/escape_sequence_unquoter_core_tb.sv
`timescale 1ns / 100ps

module escape_sequence_unquoter_core_tb;
    import esu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 100;
    localparam int REPORT_MAX   = 10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_U_WIDE = 8'h55;
    localparam string      ESC_LETTERS = "abfnrtv";

    typedef enum logic [2:0] {
        PM_TEXT,
        PM_ESC,
        PM_PLUS,
        PM_DIGITS,
        PM_SKIP
    } t_parse;

    logic i_clk = 1'b0;
    logic i_rst_n;

    esu_in_if  in_ch ();
    esu_out_if out_ch ();

    escape_sequence_unquoter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_parse      pmode = PM_TEXT;
    logic        wide_digits = 1'b0;
    logic [3:0]  digit_num = 4'd0;
    logic [31:0] code_acc = 32'd0;
    t_res        pending_res[$];

    int   mismatches = 0;
    int   cycles = 0;
    int   words_sent = 0;
    bit   idle_in = 1'b1;
    bit   idle_out = 1'b1;
    bit   hold_rx = 1'b0;
    logic hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void push_res(logic [7:0] d, t_status s, logic l);
        t_res r;
        r.data   = d;
        r.status = s;
        r.last   = l;
        pending_res.push_back(r);
    endfunction

    function automatic int hex_val(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic bit emit_code_point();
        logic [31:0] c;
        c = code_acc;
        if (c > 32'h10FFFF || (c >= 32'hD800 && c <= 32'hDFFF)) begin
            push_res(8'h00, ST_CODE, 1'b1);
            return 1'b0;
        end
        if (c < 32'h80) begin
            push_res(c[7:0], ST_DATA, 1'b0);
        end else if (c < 32'h800) begin
            push_res({3'b110, c[10:6]}, ST_DATA, 1'b0);
            push_res({2'b10, c[5:0]}, ST_DATA, 1'b0);
        end else if (c < 32'h10000) begin
            push_res({4'b1110, c[15:12]}, ST_DATA, 1'b0);
            push_res({2'b10, c[11:6]}, ST_DATA, 1'b0);
            push_res({2'b10, c[5:0]}, ST_DATA, 1'b0);
        end else begin
            push_res({5'b11110, c[20:18]}, ST_DATA, 1'b0);
            push_res({2'b10, c[17:12]}, ST_DATA, 1'b0);
            push_res({2'b10, c[11:6]}, ST_DATA, 1'b0);
            push_res({2'b10, c[5:0]}, ST_DATA, 1'b0);
        end
        return 1'b1;
    endfunction

    function automatic void decode_word(logic [7:0] b, logic e);
        logic       fin;
        logic       as_text;
        logic [7:0] v;
        int         h;
        fin     = e || (b == CH_NUL);
        as_text = 1'b0;
        case (pmode)
            PM_ESC: begin
                if (fin) begin
                    push_res(8'h00, ST_BAD, 1'b1);
                    pmode = PM_TEXT;
                end else if (b == CH_U || b == CH_U_WIDE) begin
                    wide_digits = (b == CH_U_WIDE);
                    pmode = PM_PLUS;
                end else begin
                    v = b;
                    case (b)
                        "a": v = 8'd7;
                        "b": v = 8'd8;
                        "f": v = 8'd12;
                        "n": v = 8'd10;
                        "r": v = 8'd13;
                        "t": v = 8'd9;
                        "v": v = 8'd11;
                        default: v = b;
                    endcase
                    push_res(v, ST_DATA, 1'b0);
                    pmode = PM_TEXT;
                end
            end
            PM_PLUS: begin
                if (!fin && b == CH_PLUS) begin
                    digit_num = 4'd0;
                    code_acc  = 32'd0;
                    pmode     = PM_DIGITS;
                end else begin
                    push_res(8'h00, ST_BAD, 1'b1);
                    pmode = fin ? PM_TEXT : PM_SKIP;
                end
            end
            PM_DIGITS: begin
                h = fin ? -1 : hex_val(b);
                if (h >= 0) begin
                    code_acc  = {code_acc[27:0], h[3:0]};
                    digit_num = digit_num + 4'd1;
                    if (digit_num >= (wide_digits ? 4'd8 : 4'd4)) begin
                        pmode = emit_code_point() ? PM_TEXT : PM_SKIP;
                    end
                end else if (!emit_code_point()) begin
                    pmode = fin ? PM_TEXT : PM_SKIP;
                end else begin
                    pmode   = PM_TEXT;
                    as_text = 1'b1;
                end
            end
            PM_SKIP: begin
                if (fin) pmode = PM_TEXT;
            end
            default: begin
                pmode   = PM_TEXT;
                as_text = 1'b1;
            end
        endcase
        if (as_text) begin
            if (fin) begin
                push_res(8'h00, ST_END, 1'b1);
            end else if (b == CH_BSL) begin
                pmode = PM_ESC;
            end else begin
                push_res(b, ST_DATA, 1'b0);
            end
        end
    endfunction

    // The word is held until taken, so its results are predicted as soon as it is offered.
    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        gap = idle_in ? $urandom_range(0, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.is_end  <= e;
        decode_word(b, e);
        words_sent++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_word(s[k], 1'b0);
    endtask

    task automatic send_end();
        if ($urandom_range(0, 1)) send_word(8'($urandom_range(0, 255)), 1'b1);
        else send_word(CH_NUL, 1'b0);
    endtask

    task automatic send_code_point();
        logic [31:0] v;
        logic        wide;
        logic [3:0]  nib;
        logic [7:0]  ch;
        int          n;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 32'h7F);
            1: v = $urandom_range(32'h80, 32'h7FF);
            2: v = $urandom_range(32'h800, 32'hFFFF);
            3: v = $urandom_range(32'h10000, 32'h10FFFF);
            4: v = $urandom_range(32'hD800, 32'hDFFF);
            default: v = $urandom_range(32'h110000, 32'hFFFFFFFF);
        endcase
        wide = (v > 32'hFFFF) ? 1'b1 : 1'($urandom_range(0, 1));
        n = 0;
        for (int k = 0; k < 8; k++) begin
            if (v[4*k +: 4] != 4'd0) n = k + 1;
        end
        if ($urandom_range(0, 1)) n = wide ? 8 : 4;
        send_word(CH_BSL, 1'b0);
        send_word(wide ? CH_U_WIDE : CH_U, 1'b0);
        send_word(CH_PLUS, 1'b0);
        for (int k = n - 1; k >= 0; k--) begin
            nib = v[4*k +: 4];
            if (nib < 4'd10) ch = 8'h30 + 8'(nib);
            else ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
            send_word(ch, 1'b0);
        end
    endtask

    task automatic send_random_token();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
            b = 8'($urandom_range(1, 255));
            send_word((b == CH_BSL) ? CH_PLUS : b, 1'b0);
        end else if (kind < 11) begin
            send_word(CH_BSL, 1'b0);
            if ($urandom_range(0, 1)) b = ESC_LETTERS[$urandom_range(0, 6)];
            else b = 8'($urandom_range(0, 255));
            send_word(b, 1'b0);
        end else if (kind < 17) begin
            send_code_point();
        end else if (kind < 19) begin
            send_word(CH_BSL, 1'b0);
            send_word($urandom_range(0, 1) ? CH_U_WIDE : CH_U, 1'b0);
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_plain_bytes();
        send_word(8'h01, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hA5, 1'b1);
    endtask

    task automatic test_escapes();
        send_text("\\n\\v\\q\\\\");
        send_word(CH_NUL, 1'b0);
    endtask

    task automatic test_code_points();
        send_text("\\U+10fFFFz\\u+7FF\\u+20ACa\\u+");
        send_word(CH_NUL, 1'b0);
    endtask

    task automatic test_errors();
        send_text("\\u+d800x");
        send_word(CH_NUL, 1'b0);
        send_text("\\u{");
        send_word(8'h5A, 1'b1);
        send_text("\\U+110000");
        send_word(CH_NUL, 1'b1);
        send_text("\\");
        send_word(8'h3C, 1'b1);
        send_text("\\u");
        send_word(CH_NUL, 1'b0);
    endtask

    task automatic test_backpressure();
        idle_in  = 1'b0;
        hold_req = ~hold_req;
        repeat (6) begin
            repeat (3) send_code_point();
            send_end();
        end
        wait_drain();
        idle_in = 1'b1;
    endtask

    task automatic test_random_strings();
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            idle_in  = $urandom_range(0, 3) != 0;
            idle_out = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 8)) send_random_token();
            send_end();
        end
    endtask

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_res.size() == 0) begin
                note_error($sformatf("unexpected result: data %02h status %0d last %0b",
                                     out_ch.out_byte, out_ch.status, out_ch.last));
            end else begin
                want = pending_res.pop_front();
                if (out_ch.out_byte !== want.data || out_ch.status !== want.status
                        || out_ch.last !== want.last) begin
                    note_error($sformatf({"mismatch: expected data %02h status %0d last %0b,",
                                          " got data %02h status %0d last %0b"},
                                         want.data, want.status, want.last,
                                         out_ch.out_byte, out_ch.status, out_ch.last));
                end
            end
        end
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = idle_out ? $urandom_range(0, 15) : 0;
            @(negedge i_clk);
            if (stall > 0 || hold_rx) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                while (hold_rx) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        forever begin
            @(hold_req);
            hold_rx = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_rx = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.is_end  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_bytes();
        test_escapes();
        test_code_points();
        test_errors();
        test_backpressure();
        test_random_strings();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/esu_pkg.sv
sv/esu_channels.sv
sv/esu_decode.sv
sv/escape_sequence_unquoter_core.sv
tb/escape_sequence_unquoter_core_tb.sv
